// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/spam_pkg.sv =====
// ----------------------------------------------------------------------------
// spam_pkg
// Types and constants for the sparse polynomial add/multiply block.
// ----------------------------------------------------------------------------
`default_nettype none
package spam_pkg;
    localparam int MaxTerms   = 8;
    localparam int CoefBits   = 16;
    localparam int WorkDepth  = 64;
    localparam int OpCoefW    = 24;
    localparam int OpPowW     = 15;
    localparam int ResCoefW   = 56;
    localparam int ResPowW    = 16;

    typedef enum logic [2:0] {
        REQ_LOAD_A = 3'd0,
        REQ_LOAD_B = 3'd1,
        REQ_SUM    = 3'd2,
        REQ_PROD   = 3'd3,
        REQ_CLEAR  = 3'd4
    } t_req;

    // term travelling along the work chain
    typedef struct packed {
        logic                       vld;
        logic signed [ResCoefW-1:0] coef;
        logic [ResPowW-1:0]         pow;
    } t_term;

    function automatic logic signed [OpCoefW-1:0] sat24(input logic signed [OpCoefW:0] v);
        logic signed [OpCoefW:0] mx;
        logic signed [OpCoefW:0] mn;
        begin
            mx = (OpCoefW+1)'(2**(OpCoefW-1) - 1);
            mn = -(OpCoefW+1)'(2**(OpCoefW-1));
            if (v > mx)      sat24 = mx[OpCoefW-1:0];
            else if (v < mn) sat24 = mn[OpCoefW-1:0];
            else             sat24 = v[OpCoefW-1:0];
        end
    endfunction
endpackage
`default_nettype wire

// ===== rtl/spam_cell.sv =====
// ----------------------------------------------------------------------------
// spam_cell
// One slot of the sorted work chain. Holds one term; a term arriving from
// the left is taken by an empty slot, merges (equal power), is passed on
// (lower power), or displaces the held term which moves on to the right.
// ----------------------------------------------------------------------------
`default_nettype none
module spam_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_clr,
    input  wire logic            i_shift,
    input  wire spam_pkg::t_term i_term,
    input  wire spam_pkg::t_term i_next,
    output spam_pkg::t_term      o_term,
    output spam_pkg::t_term      o_hold
);
    import spam_pkg::*;

    t_term r_hold, n_hold, n_out;

    // i_shift: emit mode, the chain moves left (take neighbour on the right)
    always_comb begin
        n_hold = r_hold;
        n_out  = '0;
        if (i_shift) begin
            n_hold = i_next;
        end else if (i_term.vld) begin
            if (!r_hold.vld) begin
                n_hold = i_term;
            end else if (r_hold.pow == i_term.pow) begin
                n_hold.coef = r_hold.coef + i_term.coef;
            end else if (i_term.pow > r_hold.pow) begin
                n_hold = i_term;
                n_out  = r_hold;
            end else begin
                n_out = i_term;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_hold <= '0;
            o_term <= '0;
        end else begin
            r_hold <= n_hold;
            o_term <= n_out;
        end
    end

    assign o_hold = r_hold;
endmodule
`default_nettype wire

// ===== rtl/sparse_polynomial_add_multiply.sv =====
// ----------------------------------------------------------------------------
// sparse_polynomial_add_multiply
// Sparse polynomial sum/product over two sorted operand tables.
// ----------------------------------------------------------------------------
// channel   dir  fields (tdata low->high)         tlast  tuser
// s_axis    in   coef[15:0] power[30:16]          -      req_type
// m_axis    out  coef_res[55:0] power_res[71:56]  last   dropped
//
// A load is taken in S_IDLE and written in S_LOAD; a clear acts when taken. An
// emit feeds na+nb (sum) or na*nb (product, via r_mul) terms into a chain of
// WorkDepth cells, one per cycle, waits in S_SETTLE for the chain to settle,
// then shifts it out one term per cycle with m_axis_tready high; zero terms use such a cycle unseen.
// Reset clears counts, flags and chain valid bits; no clearing pass.
// A stalled output holds the chain; input is refused until emission ends.
// ----------------------------------------------------------------------------
`default_nettype none
module sparse_polynomial_add_multiply #(
    parameter int MAX_TERMS = spam_pkg::MaxTerms,
    parameter int COEF_BITS = spam_pkg::CoefBits
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // coef[15:0], power[30:16]
    input  wire logic [2:0]  s_axis_tuser,  // req_type
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,  // coef_res[55:0], power_res[71:56]
    output logic             m_axis_tlast,
    output logic             m_axis_tuser   // dropped
);
    import spam_pkg::*;
    `include "assert_macros.svh"

    localparam int IW = $clog2(MAX_TERMS+1);
    localparam int SW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int WW = $clog2(WorkDepth+1);

    typedef enum logic [2:0] {S_IDLE, S_LOAD, S_FEED, S_SETTLE, S_OUT, S_ZERO} t_state;

    t_state r_state;
    logic [OpPowW-1:0]         r_aexp [MAX_TERMS];
    logic signed [OpCoefW-1:0] r_acoef[MAX_TERMS];
    logic [OpPowW-1:0]         r_bexp [MAX_TERMS];
    logic signed [OpCoefW-1:0] r_bcoef[MAX_TERMS];
    logic [IW-1:0] r_acnt, r_bcnt;
    logic          r_drop;
    logic          r_selb;
    logic signed [OpCoefW-1:0] r_c;
    logic [OpPowW-1:0]         r_p;
    logic [IW-1:0] r_i, r_j;
    logic [WW-1:0] r_wait;
    logic          r_prod;
    logic          r_any;
    t_term         r_feed;
    t_term         r_mul;

    // input decode
    logic signed [COEF_BITS-1:0] w_cin;
    assign w_cin = s_axis_tdata[COEF_BITS-1:0];
    assign s_axis_tready = (r_state == S_IDLE);
    wire w_acc = s_axis_tvalid && s_axis_tready;

    // load: find match / insertion place in selected table
    logic [OpPowW-1:0]         w_ex [MAX_TERMS];
    logic signed [OpCoefW-1:0] w_co [MAX_TERMS];
    logic [IW-1:0] w_n;
    logic          w_hit;
    logic [SW-1:0] w_hidx;
    logic [IW-1:0] w_pos;
    always_comb begin
        w_n    = r_selb ? r_bcnt : r_acnt;
        w_hit  = 1'b0;
        w_hidx = '0;
        w_pos  = '0;
        for (int k = 0; k < MAX_TERMS; k++) begin
            w_ex[k] = r_selb ? r_bexp[k] : r_aexp[k];
            w_co[k] = r_selb ? r_bcoef[k] : r_acoef[k];
            if (IW'(k) < w_n) begin
                if (w_ex[k] == r_p) begin
                    w_hit  = 1'b1;
                    w_hidx = SW'(k);
                end
                if (w_ex[k] > r_p) w_pos = IW'(k + 1);
            end
        end
    end

    // operand pair being fed
    logic [SW-1:0] w_ia, w_ib;
    assign w_ia = r_i[SW-1:0];
    assign w_ib = r_j[SW-1:0];

    logic signed [2*OpCoefW-1:0] w_prod;
    assign w_prod = r_acoef[w_ia] * r_bcoef[w_ib];

    // work chain
    t_term w_in  [WorkDepth+1];
    t_term w_hold[WorkDepth+1];
    logic  w_clr, w_shift;
    assign w_in[0]           = r_feed;
    assign w_hold[WorkDepth] = '0;
    assign w_clr   = w_acc && (s_axis_tuser == REQ_SUM || s_axis_tuser == REQ_PROD);
    assign w_shift = (r_state == S_OUT) && m_axis_tready && r_any;

    for (genvar g = 0; g < WorkDepth; g++) begin : g_cell
        spam_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_clr  (w_clr),
            .i_shift(w_shift),
            .i_term (w_in[g]),
            .i_next (w_hold[g+1]),
            .o_term (w_in[g+1]),
            .o_hold (w_hold[g])
        );
    end

    // head of chain, skipping zero terms
    wire w_head_ok = w_hold[0].vld && (w_hold[0].coef != '0);
    logic w_more;
    always_comb begin
        w_more = 1'b0;
        for (int k = 1; k < WorkDepth; k++)
            if (w_hold[k].vld && w_hold[k].coef != '0) w_more = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_acnt  <= '0;
            r_bcnt  <= '0;
            r_drop  <= 1'b0;
            r_feed  <= '0;
            r_mul   <= '0;
            r_any   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_c    <= OpCoefW'(w_cin);
                        r_p    <= s_axis_tdata[16 +: OpPowW];
                        r_selb <= (s_axis_tuser == REQ_LOAD_B);
                        r_i    <= '0;
                        r_j    <= '0;
                        r_prod <= (s_axis_tuser == REQ_PROD);
                        priority case (s_axis_tuser)
                            REQ_LOAD_A, REQ_LOAD_B: r_state <= S_LOAD;
                            REQ_SUM, REQ_PROD:      r_state <= S_FEED;
                            REQ_CLEAR: begin
                                r_acnt <= '0;
                                r_bcnt <= '0;
                                r_drop <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_LOAD: begin
                    r_state <= S_IDLE;
                    if (w_hit) begin
                        if (r_selb) r_bcoef[w_hidx] <= sat24(
                            (OpCoefW+1)'(w_co[w_hidx]) + (OpCoefW+1)'(r_c));
                        else r_acoef[w_hidx] <= sat24(
                            (OpCoefW+1)'(w_co[w_hidx]) + (OpCoefW+1)'(r_c));
                    end else if (w_n >= IW'(MAX_TERMS)) begin
                        r_drop <= 1'b1;
                    end else begin
                        for (int k = 0; k < MAX_TERMS; k++) begin
                            if (IW'(k) == w_pos) begin
                                if (r_selb) begin
                                    r_bexp[k] <= r_p; r_bcoef[k] <= r_c;
                                end else begin
                                    r_aexp[k] <= r_p; r_acoef[k] <= r_c;
                                end
                            end
                        end
                        for (int k = 1; k < MAX_TERMS; k++) begin
                            if (IW'(k) > w_pos) begin
                                if (r_selb) begin
                                    r_bexp[k] <= r_bexp[k-1]; r_bcoef[k] <= r_bcoef[k-1];
                                end else begin
                                    r_aexp[k] <= r_aexp[k-1]; r_acoef[k] <= r_acoef[k-1];
                                end
                            end
                        end
                        if (r_selb) r_bcnt <= r_bcnt + 1'b1;
                        else        r_acnt <= r_acnt + 1'b1;
                    end
                end
                S_FEED: begin
                    r_wait <= '0;
                    if (r_prod) begin
                        if (r_i < r_acnt && r_bcnt != '0) begin
                            r_mul <= '{1'b1, ResCoefW'(w_prod),
                                       ResPowW'(r_aexp[w_ia]) + ResPowW'(r_bexp[w_ib])};
                            if (r_j + 1'b1 == r_bcnt) begin
                                r_j <= '0; r_i <= r_i + 1'b1;
                            end else r_j <= r_j + 1'b1;
                        end else begin
                            r_mul   <= '0;
                            r_state <= S_SETTLE;
                        end
                        r_feed <= r_mul;
                    end else begin
                        if (r_i < r_acnt) begin
                            r_feed <= '{1'b1, ResCoefW'(r_acoef[w_ia]), ResPowW'(r_aexp[w_ia])};
                            r_i <= r_i + 1'b1;
                        end else if (r_j < r_bcnt) begin
                            r_feed <= '{1'b1, ResCoefW'(r_bcoef[w_ib]), ResPowW'(r_bexp[w_ib])};
                            r_j <= r_j + 1'b1;
                        end else begin
                            r_feed  <= '0;
                            r_state <= S_SETTLE;
                        end
                    end
                end
                S_SETTLE: begin
                    r_feed <= r_mul;
                    r_mul  <= '0;
                    r_wait <= r_wait + 1'b1;
                    if (r_wait == WW'(WorkDepth)) r_state <= S_OUT;
                    r_any <= 1'b1;
                end
                S_OUT: begin
                    if (!w_head_ok && r_any) begin
                        // skip a zero or empty head
                        if (!w_hold[0].vld && !w_more) begin
                            r_any   <= 1'b0;
                            r_state <= S_ZERO;
                        end
                    end else if (m_axis_tready && !w_more) begin
                        r_state <= S_IDLE;
                    end
                end
                S_ZERO: if (m_axis_tready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // the empty-result term is offered only if nothing went out since the emit
    logic r_seen;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clr) r_seen <= 1'b0;
        else if (m_axis_tvalid && m_axis_tready) r_seen <= 1'b1;
    end

    assign m_axis_tvalid = ((r_state == S_OUT) && w_head_ok)
                        || ((r_state == S_ZERO) && !r_seen);
    assign m_axis_tdata  = (r_state == S_OUT) ? {w_hold[0].pow, w_hold[0].coef} : '0;
    assign m_axis_tlast  = (r_state == S_ZERO) || !w_more;
    assign m_axis_tuser  = r_drop;

    `ASSERT_IMPL(a_no_in_busy, i_clk, i_rst_n, r_state != S_IDLE, !s_axis_tready)
    `ASSERT_IMPL(a_cnt_a, i_clk, i_rst_n, 1'b1, r_acnt <= IW'(MAX_TERMS))
    `ASSERT_IMPL(a_cnt_b, i_clk, i_rst_n, 1'b1, r_bcnt <= IW'(MAX_TERMS))
    `ASSERT_NEXT(a_clr, i_clk, i_rst_n,
        w_acc && s_axis_tuser == REQ_CLEAR, !r_drop && r_acnt == '0)
endmodule
`default_nettype wire

// ===== sim/sparse_polynomial_add_multiply_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_polynomial_add_multiply_tb
// Drives load, emit, clear and unused request codes into the sparse polynomial
// block and checks every emitted term against a behavioural model of the operand
// tables, with random gaps on the input and random back-pressure on the output.
// ----------------------------------------------------------------------------
module sparse_polynomial_add_multiply_tb;
    import spam_pkg::*;

    typedef struct {
        logic signed [55:0] coef;
        logic [15:0]        pow;
        logic               last;
        logic               dropped;
    } t_poly_term;

    class poly_scoreboard;
        logic [14:0]        a_pow[8];
        logic signed [23:0] a_coef[8];
        int                 a_n;
        logic [14:0]        b_pow[8];
        logic signed [23:0] b_coef[8];
        int                 b_n;
        bit                 drop_sticky;
        t_poly_term         pending_terms[$];
        int                 errors;
        int                 terms_checked;

        function void load(bit to_b, logic signed [15:0] c, logic [14:0] p);
            logic [14:0]        ex[8];
            logic signed [23:0] co[8];
            logic signed [24:0] s;
            int                 n;
            int                 pos;
            if (to_b) begin ex = b_pow; co = b_coef; n = b_n; end
            else begin ex = a_pow; co = a_coef; n = a_n; end
            for (int i = 0; i < n; i++) begin
                if (ex[i] == p) begin
                    s = 25'(co[i]) + 25'(c);
                    if (s > 25'sd8388607) co[i] = 24'sd8388607;
                    else if (s < -25'sd8388608) co[i] = -24'sd8388608;
                    else co[i] = s[23:0];
                    pos = -1;
                    break;
                end
                pos = 0;
            end
            if (n == 0) pos = 0;
            if (pos != -1) begin
                if (n >= MaxTerms) drop_sticky = 1;
                else begin
                    pos = 0;
                    while (pos < n && ex[pos] > p) pos++;
                    for (int i = n; i > pos; i--) begin
                        ex[i] = ex[i-1]; co[i] = co[i-1];
                    end
                    ex[pos] = p; co[pos] = c; n++;
                end
            end
            if (to_b) begin b_pow = ex; b_coef = co; b_n = n; end
            else begin a_pow = ex; a_coef = co; a_n = n; end
        endfunction

        function void note_request(logic [2:0] req, logic [31:0] data);
            logic signed [55:0] wc[$];
            logic [15:0]        wp[$];
            logic signed [55:0] c;
            logic [15:0]        p;
            int                 pos;
            bit                 hit;
            int                 k;
            t_poly_term         t;
            case (req)
                REQ_LOAD_A: load(0, data[15:0], data[30:16]);
                REQ_LOAD_B: load(1, data[15:0], data[30:16]);
                REQ_CLEAR: begin a_n = 0; b_n = 0; drop_sticky = 0; end
                REQ_SUM, REQ_PROD: begin
                    for (int i = 0; i < (req == REQ_SUM ? a_n + b_n : a_n * b_n); i++) begin
                        if (req == REQ_SUM) begin
                            if (i < a_n) begin c = a_coef[i]; p = a_pow[i]; end
                            else begin c = b_coef[i-a_n]; p = b_pow[i-a_n]; end
                        end else begin
                            c = 56'(a_coef[i / b_n]) * 56'(b_coef[i % b_n]);
                            p = 16'(a_pow[i / b_n]) + 16'(b_pow[i % b_n]);
                        end
                        hit = 0;
                        foreach (wp[j]) if (wp[j] == p) begin wc[j] += c; hit = 1; end
                        if (!hit) begin
                            pos = 0;
                            while (pos < wp.size() && wp[pos] > p) pos++;
                            wp.insert(pos, p); wc.insert(pos, c);
                        end
                    end
                    k = 0;
                    foreach (wp[j]) if (wc[j] != 0) begin
                        t.coef = wc[j]; t.pow = wp[j]; t.last = 0;
                        t.dropped = drop_sticky;
                        pending_terms.push_back(t); k++;
                    end
                    if (k == 0) begin
                        t.coef = 0; t.pow = 0; t.dropped = drop_sticky;
                        pending_terms.push_back(t);
                    end
                    pending_terms[$].last = 1;
                end
                default: ;
            endcase
        endfunction

        function void check_term(logic [71:0] data, logic last, logic dropped);
            t_poly_term t;
            terms_checked++;
            if (pending_terms.size() == 0) begin
                $display("%0t: unexpected term %h last %b dropped %b", $time, data, last,
                         dropped);
                errors++;
                return;
            end
            t = pending_terms.pop_front();
            if (data[55:0] !== t.coef || data[71:56] !== t.pow || last !== t.last ||
                dropped !== t.dropped) begin
                $display("%0t: expected coef %0d pow %0d last %b dropped %b, ",
                         $time, t.coef, t.pow, t.last, t.dropped,
                         "got coef %0d pow %0d last %b dropped %b",
                         $signed(data[55:0]), data[71:56], last, dropped);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = 0;  // coef[15:0], power[30:16]
    logic [2:0]  s_axis_tuser = 0;  // req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [71:0] m_axis_tdata;      // coef_res[55:0], power_res[71:56]
    logic        m_axis_tlast;
    logic        m_axis_tuser;      // dropped

    poly_scoreboard sb = new();
    bit             hold_off = 0;
    int             requests_sent = 0;

    sparse_polynomial_add_multiply dut (.*);

    always #4 i_clk = ~i_clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_request(logic [2:0] req, logic [15:0] c, logic [14:0] p);
        int g;
        s_axis_tvalid <= 1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {1'b0, p, c};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request(req, {1'b0, p, c});
        requests_sent++;
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (sb.pending_terms.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 6)) - 16'd3;
            default: return 16'($urandom);
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_term(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end

    initial begin : receiver
        int g;
        @(posedge i_rst_n);
        forever begin
            if (hold_off) begin
                m_axis_tready <= 0;
                repeat (300) @(posedge i_clk);
                hold_off = 0;
            end
            g = ($urandom_range(0, 4) == 0) ? gap_len() : 0;
            m_axis_tready <= (g == 0);
            @(posedge i_clk);
            if (g > 1) repeat (g - 1) @(posedge i_clk);
        end
    end

    initial begin
        #25000000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        logic [2:0] r;
        logic [14:0] p;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: empty emits, extremes, repeated merges, full table, drop, unused codes, clear
        send_request(REQ_SUM, 0, 0);
        send_request(REQ_PROD, 0, 0);
        send_request(REQ_LOAD_A, 16'h7fff, 15'h7fff);
        send_request(REQ_LOAD_B, 16'h8000, 15'h7fff);
        send_request(REQ_LOAD_B, 16'h0000, 15'd0);
        send_request(REQ_PROD, 0, 0);
        send_request(REQ_SUM, 0, 0);
        for (int i = 0; i < 30; i++) send_request(REQ_LOAD_A, 16'h7fff, 15'd5);
        for (int i = 0; i < 9; i++) send_request(REQ_LOAD_B, 16'(16'h8000 + i), 15'(i * 3));
        send_request(3'd5, 16'hffff, 15'h7fff);
        send_request(3'd7, 0, 0);
        send_request(REQ_SUM, 0, 0);
        send_request(REQ_PROD, 0, 0);
        send_request(REQ_CLEAR, 0, 0);
        send_request(REQ_SUM, 0, 0);
        drain();
        // random: mostly loads, mixed with emits, clears and unused codes
        while (requests_sent < 220) begin
            if (requests_sent > 150 && requests_sent < 160) hold_off = 1;
            r = 3'($urandom_range(0, 99) < 8 ? REQ_CLEAR :
                   $urandom_range(0, 99) < 60 ? $urandom_range(0, 1) :
                   $urandom_range(0, 99) < 90 ? $urandom_range(2, 3) : $urandom_range(5, 7));
            p = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(0, 12));
            send_request(r, rand_coef(), p);
            if ($urandom_range(0, 60) == 0) drain();
        end
        drain();
        $display("Covered %0d requests and %0d emitted terms, with table overflow,",
                 requests_sent, sb.terms_checked);
        $display("repeated merges, empty results and long output stalls.");
        if (sb.errors == 0 && sb.pending_terms.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/spam_pkg.sv
rtl/spam_cell.sv
rtl/sparse_polynomial_add_multiply.sv
sim/sparse_polynomial_add_multiply_tb.sv
